// ===== rtl/ncad_pkg.sv =====
// Shared types and constants for the nearest-centroid assignment block.
// Used by ncad_cell and nearest_centroid_assign; depends on nothing.
package ncad_pkg;

    localparam int MAX_CENTROIDS = 16;
    localparam int MAX_DIMS      = 16;
    localparam int COORD_BITS    = 16;
    localparam int DIST_BITS     = 40;
    localparam int SQ_BITS       = 2 * (COORD_BITS + 1);
    localparam int IDX_BITS      = 4;
    localparam int DIM_BITS      = 4;
    localparam int CNT_BITS      = 5;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_CENTROIDS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_DIMS      = 1'b1;

    localparam logic [CNT_BITS-1:0] CNT_RESET = CNT_BITS'(16);

    // Point coordinate travelling down the cell chain with the running best
    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] coord;
        logic [DIM_BITS-1:0]          dim;
        logic                         clr;
        logic                         res;
        logic                         fin;
        logic [IDX_BITS-1:0]          best_idx;
        logic [DIST_BITS-1:0]         best_dist;
    } t_tok;

    // Centroid coordinate write into one cell
    typedef struct packed {
        logic                         we;
        logic [DIM_BITS-1:0]          dim;
        logic signed [COORD_BITS-1:0] value;
    } t_load;

    // Clamp a register value to 1..maxv
    function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] v,
                                                        input logic [CNT_BITS-1:0] maxv);
        logic [CNT_BITS-1:0] r;
        if (v == '0) begin
            r = CNT_BITS'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ncad_cell.sv =====
// One centroid cell: its coordinates, its distance accumulator and one step
// of the running minimum. Depends on ncad_pkg.
module ncad_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [ncad_pkg::IDX_BITS-1:0]      i_cell_idx,
    input  logic                               i_active,
    input  ncad_pkg::t_load                    i_load,
    input  ncad_pkg::t_tok                     i_tok,
    output ncad_pkg::t_tok                     o_tok
);

    logic signed [ncad_pkg::COORD_BITS-1:0] r_coord [ncad_pkg::MAX_DIMS];
    logic [ncad_pkg::DIST_BITS-1:0]         r_acc, n_acc;
    logic [ncad_pkg::SQ_BITS-1:0]           r_sq;
    ncad_pkg::t_tok                         r_tok, r_out, n_out;

    logic signed [ncad_pkg::COORD_BITS:0]   w_diff;
    logic signed [ncad_pkg::SQ_BITS-1:0]    w_sq;
    logic [ncad_pkg::DIST_BITS-1:0]         w_base, w_sat;
    logic [ncad_pkg::DIST_BITS:0]           w_sum;

    // Coordinate store, written in load mode
    always_ff @(posedge i_clk) begin
        if (i_load.we) begin
            r_coord[i_load.dim] <= i_load.value;
        end
    end

    // Stage one: squared difference
    assign w_diff = {i_tok.coord[ncad_pkg::COORD_BITS-1], i_tok.coord}
                  - {r_coord[i_tok.dim][ncad_pkg::COORD_BITS-1], r_coord[i_tok.dim]};
    assign w_sq   = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        r_sq <= ncad_pkg::SQ_BITS'(w_sq);
    end

    // Stage two: accumulate with saturation, then compare with the best so far
    always_comb begin
        w_base = r_tok.clr ? '0 : r_acc;
        w_sum  = {1'b0, w_base} + (ncad_pkg::DIST_BITS+1)'(r_sq);
        w_sat  = w_sum[ncad_pkg::DIST_BITS] ? ncad_pkg::DIST_MAX
                                            : w_sum[ncad_pkg::DIST_BITS-1:0];
        n_acc  = r_acc;
        n_out  = r_tok;
        if (r_tok.valid) begin
            n_acc = i_active ? w_sat : w_base;
            if (i_active && (w_sat < r_tok.best_dist)) begin
                n_out.best_dist = w_sat;
                n_out.best_idx  = i_cell_idx;
            end
        end
    end

    // Advance the item and the accumulator through this cell's registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_out.valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_tok <= i_tok;
            r_out <= n_out;
            r_acc <= n_acc;
        end
    end

    assign o_tok = r_out;

endmodule

// ===== rtl/nearest_centroid_assign.sv =====
// Top level of the nearest-centroid assignment block: control, configuration
// and the chain of ncad_cell instances. Depends on ncad_pkg and ncad_cell.
//
// Load-mode items write one centroid coordinate and never make the block
// busy. A point coordinate runs down a chain of MAX_CENTROIDS cells, two
// register stages per cell (squared difference, then accumulate and
// compare). A coordinate that is not the last active one holds off the next
// item until it leaves the chain. The last active coordinate holds it off
// until its result moves from the pending register into the output
// register, which waits while that register holds an earlier result that
// has not been accepted. A coordinate beyond the active dims is dropped
// without making the block busy. The result waits in the output register,
// and the next item is accepted while it waits.
module nearest_centroid_assign (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [ncad_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [ncad_pkg::CNT_BITS-1:0]         i_cfg_data,
    // input items
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic [ncad_pkg::IDX_BITS-1:0]         i_centroid_slot,
    input  logic [ncad_pkg::DIM_BITS-1:0]         i_dim_index,
    input  logic signed [ncad_pkg::COORD_BITS-1:0] i_coord_value,
    input  logic                                  i_final_point,
    // result items
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ncad_pkg::IDX_BITS-1:0]         o_nearest_index,
    output logic [ncad_pkg::DIST_BITS-1:0]        o_nearest_distance,
    output logic                                  o_final_assignment
);

    localparam logic [ncad_pkg::CNT_BITS-1:0] MaxC = ncad_pkg::CNT_BITS'(ncad_pkg::MAX_CENTROIDS);
    localparam logic [ncad_pkg::CNT_BITS-1:0] MaxD = ncad_pkg::CNT_BITS'(ncad_pkg::MAX_DIMS);

    logic [ncad_pkg::CNT_BITS-1:0] r_act_c, r_act_d;
    logic [ncad_pkg::CNT_BITS-1:0] w_nc, w_nd;
    logic                          w_accept, w_take;
    logic                          r_busy, r_pend;
    ncad_pkg::t_tok                r_tok0, w_tok [ncad_pkg::MAX_CENTROIDS+1];
    ncad_pkg::t_tok                w_end;
    logic [ncad_pkg::IDX_BITS-1:0] r_res_idx;
    logic [ncad_pkg::DIST_BITS-1:0] r_res_dist;
    logic                          r_res_fin;
    logic                          w_place;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_c <= ncad_pkg::CNT_RESET;
            r_act_d <= ncad_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ncad_pkg::REG_ACTIVE_CENTROIDS: r_act_c <= i_cfg_data;
                ncad_pkg::REG_ACTIVE_DIMS:      r_act_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_nc = ncad_pkg::clamp_count(r_act_c, MaxC);
    assign w_nd = ncad_pkg::clamp_count(r_act_d, MaxD);

    // Input handshake
    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_take     = w_accept && i_mode
                      && (ncad_pkg::CNT_BITS'(i_dim_index) < w_nd);

    // Launch a point coordinate into the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
        end else begin
            r_tok0.valid     <= w_take;
            r_tok0.coord     <= i_coord_value;
            r_tok0.dim       <= i_dim_index;
            r_tok0.clr       <= (i_dim_index == '0);
            r_tok0.res       <= (ncad_pkg::CNT_BITS'(i_dim_index) == (w_nd - 1'b1));
            r_tok0.fin       <= i_final_point;
            r_tok0.best_idx  <= '0;
            r_tok0.best_dist <= ncad_pkg::DIST_MAX;
        end
    end

    assign w_tok[0] = r_tok0;

    // Cell chain, one cell per centroid
    for (genvar k = 0; k < ncad_pkg::MAX_CENTROIDS; k++) begin : g_cell
        ncad_pkg::t_load w_load;
        always_comb begin
            w_load.we    = w_accept && !i_mode
                         && (i_centroid_slot == ncad_pkg::IDX_BITS'(k));
            w_load.dim   = i_dim_index;
            w_load.value = i_coord_value;
        end
        ncad_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (ncad_pkg::IDX_BITS'(k)),
            .i_active   (ncad_pkg::CNT_BITS'(k) < w_nc),
            .i_load     (w_load),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1])
        );
    end

    assign w_end   = w_tok[ncad_pkg::MAX_CENTROIDS];
    assign w_place = r_pend && (!o_out_valid || i_out_ready);

    // Hold the finished result until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
            end else if (w_end.valid && !w_end.res) begin
                r_busy <= 1'b0;
            end else if (w_place) begin
                r_busy <= 1'b0;
            end

            if (w_end.valid && w_end.res) begin
                r_pend <= 1'b1;
            end else if (w_place) begin
                r_pend <= 1'b0;
            end

            if (w_place) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        if (w_end.valid && w_end.res) begin
            r_res_idx  <= w_end.best_idx;
            r_res_dist <= w_end.best_dist;
            r_res_fin  <= w_end.fin;
        end
        if (w_place) begin
            o_nearest_index    <= r_res_idx;
            o_nearest_distance <= r_res_dist;
            o_final_assignment <= r_res_fin;
        end
    end

endmodule

// ===== bench/nearest_centroid_assign_tb.sv =====
// Self-checking testbench for nearest_centroid_assign: centroid loads, point streams,
// register settings and handshake stalls, checked against an in-bench predictor.
// Depends on ncad_pkg and the nearest_centroid_assign RTL only.
module nearest_centroid_assign_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = ncad_pkg::MAX_CENTROIDS;
    localparam int NUM_DIMS     = ncad_pkg::MAX_DIMS;
    localparam int CW           = ncad_pkg::COORD_BITS;
    localparam int DW           = ncad_pkg::DIST_BITS;
    localparam int IW           = ncad_pkg::IDX_BITS;
    localparam int NW           = ncad_pkg::DIM_BITS;
    localparam int KW           = ncad_pkg::CNT_BITS;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    // chain is two stages per cell plus in/out registers; leave generous slack
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 175;
    localparam int MAX_PRINTED  = 30;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [DW-1:0] dist_sq;
        logic          fin;
    } t_assignment;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [ncad_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [KW-1:0]        i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_mode;
    logic [IW-1:0]        i_centroid_slot;
    logic [NW-1:0]        i_dim_index;
    logic signed [CW-1:0] i_coord_value;
    logic                 i_final_point;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [IW-1:0]        o_nearest_index;
    logic [DW-1:0]        o_nearest_distance;
    logic                 o_final_assignment;

    // predictor state
    logic signed [CW-1:0] centroid_coord [NUM_SLOTS][NUM_DIMS];
    logic [DW-1:0]        dist_acc [NUM_SLOTS];
    logic [KW-1:0]        cfg_centroids;
    logic [KW-1:0]        cfg_dims;
    t_assignment          expected_assign [$];
    t_assignment          head;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int loads_sent;
    int coords_sent;
    int results_seen;
    int settings_used;
    int unsigned quiet_cycles;

    nearest_centroid_assign DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_centroid_slot    (i_centroid_slot),
        .i_dim_index        (i_dim_index),
        .i_coord_value      (i_coord_value),
        .i_final_point      (i_final_point),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_nearest_index    (o_nearest_index),
        .o_nearest_distance (o_nearest_distance),
        .o_final_assignment (o_final_assignment)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Register value as the block uses it: zero counts as one, cap at the maximum
    function automatic int unsigned count_in_use(input logic [KW-1:0] v, input int unsigned maxv);
        if (v == '0) begin
            return 1;
        end
        if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    // Update the table or the running sums; queue an assignment on the last active dim
    function automatic void predict_nearest(input logic mode, input logic [IW-1:0] slot,
                                            input logic [NW-1:0] dim,
                                            input logic signed [CW-1:0] coord,
                                            input logic fin);
        int unsigned nc;
        int unsigned nd;
        longint      diff;
        logic [DW:0] sum;
        logic [DW-1:0] best_d;
        int          best;
        t_assignment a;
        nc = count_in_use(cfg_centroids, NUM_SLOTS);
        nd = count_in_use(cfg_dims, NUM_DIMS);
        if (mode == MODE_LOAD) begin
            centroid_coord[slot][dim] = coord;
            return;
        end
        if (dim >= nd) begin
            return;
        end
        if (dim == 0) begin
            for (int c = 0; c < NUM_SLOTS; c++) dist_acc[c] = '0;
        end
        for (int c = 0; c < nc; c++) begin
            diff = longint'(coord) - longint'(centroid_coord[c][dim]);
            sum = {1'b0, dist_acc[c]} + (DW+1)'(diff * diff);
            dist_acc[c] = sum[DW] ? ncad_pkg::DIST_MAX : sum[DW-1:0];
        end
        if (dim != nd - 1) begin
            return;
        end
        // strict less-than keeps the lower index on a tie
        best = 0;
        best_d = dist_acc[0];
        for (int c = 1; c < nc; c++) begin
            if (dist_acc[c] < best_d) begin
                best_d = dist_acc[c];
                best = c;
            end
        end
        a.idx = IW'(best);
        a.dist_sq = best_d;
        a.fin = fin;
        expected_assign.push_back(a);
    endfunction

    // Coordinate near a chosen centroid, anywhere in range, or at an extreme
    function automatic logic signed [CW-1:0] pick_coord(input int c, input int d);
        int k;
        k = $urandom_range(9);
        if (k < 5) begin
            return centroid_coord[c][d] + CW'($urandom_range(512)) - CW'(256);
        end
        if (k < 9) begin
            return CW'($urandom);
        end
        case ($urandom_range(3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Send one item; starts and ends at a falling edge, valid left high for the next send
    task automatic send_item(input logic mode, input logic [IW-1:0] slot,
                             input logic [NW-1:0] dim, input logic signed [CW-1:0] coord,
                             input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_centroid_slot <= slot;
        i_dim_index     <= dim;
        i_coord_value   <= coord;
        i_final_point   <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_nearest(mode, slot, dim, coord, fin);
        if (mode == MODE_LOAD) begin
            loads_sent++;
        end else begin
            coords_sent++;
        end
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every assignment, then let the chain drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_assign.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers; only called with the block idle
    task automatic set_config(input logic [KW-1:0] nc_raw, input logic [KW-1:0] nd_raw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ncad_pkg::REG_ACTIVE_CENTROIDS;
        i_cfg_data <= nc_raw;
        @(negedge i_clk);
        i_cfg_idx  <= ncad_pkg::REG_ACTIVE_DIMS;
        i_cfg_data <= nd_raw;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_centroids = nc_raw;
        cfg_dims = nd_raw;
        settings_used++;
    endtask

    // Opposite corners, exact hits, and equidistant points that must pick index 0
    task automatic test_extreme_points();
        set_config(KW'(2), KW'(2));
        send_item(MODE_LOAD, 4'd0, 4'd0, COORD_MIN, 1'b0);
        send_item(MODE_LOAD, 4'd0, 4'd1, COORD_MAX, 1'b1);
        send_item(MODE_LOAD, 4'd1, 4'd0, COORD_MAX, 1'b0);
        send_item(MODE_LOAD, 4'd1, 4'd1, COORD_MIN, 1'b1);
        send_item(MODE_POINT, 4'hF, 4'd0, COORD_MAX, 1'b0);
        send_item(MODE_POINT, 4'hF, 4'd1, COORD_MIN, 1'b0);
        send_item(MODE_POINT, 4'h0, 4'd0, COORD_MIN, 1'b1);
        send_item(MODE_POINT, 4'h0, 4'd1, COORD_MAX, 1'b1);
        send_item(MODE_POINT, 4'h5, 4'd0, '0, 1'b0);
        send_item(MODE_POINT, 4'hA, 4'd1, '0, 1'b0);
        send_item(MODE_POINT, 4'h3, 4'd0, '1, 1'b0);
        send_item(MODE_POINT, 4'hC, 4'd1, '1, 1'b1);
    endtask

    // Dims past the active count, a last dim on stale sums, and a repeated dim zero
    task automatic test_dim_order();
        send_item(MODE_POINT, 4'd0, 4'd2, COORD_MAX, 1'b1);
        send_item(MODE_POINT, 4'd0, 4'hF, COORD_MIN, 1'b0);
        send_item(MODE_POINT, 4'd7, 4'd1, CW'(5), 1'b1);
        send_item(MODE_POINT, 4'd7, 4'd0, -CW'(7), 1'b0);
        send_item(MODE_POINT, 4'd7, 4'd0, CW'(1234), 1'b0);
        send_item(MODE_POINT, 4'd7, 4'd1, CW'(100), 1'b1);
    endtask

    // Write every table entry so any later setting reads only loaded values
    task automatic test_table_fill();
        logic signed [CW-1:0] v;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                v = CW'($urandom);
                if ((s * NUM_DIMS + d) % 5 == 0) begin
                    v = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                end
                send_item(MODE_LOAD, IW'(s), NW'(d), v, 1'(($urandom_range(1))));
            end
        end
    endtask

    // One setting under one idling pattern: mostly whole points, some loads and noise
    task automatic run_phase(input logic [KW-1:0] nc_raw, input logic [KW-1:0] nd_raw,
                             input int send_pct, input int recv_pct);
        int unsigned nc;
        int unsigned nd;
        int counted;
        int set_left;
        int sel;
        int near;
        int d;
        logic fin;
        wait_idle();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        set_config(nc_raw, nd_raw);
        nc = count_in_use(nc_raw, NUM_SLOTS);
        nd = count_in_use(nd_raw, NUM_DIMS);
        counted = 0;
        set_left = $urandom_range(1, 6);
        while (counted < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 72) begin
                // whole point, flagged final on the last point of its set
                set_left--;
                fin = (set_left == 0);
                if (set_left == 0) begin
                    set_left = $urandom_range(1, 6);
                end
                near = $urandom_range(nc - 1);
                for (int k = 0; k < nd; k++) begin
                    send_item(MODE_POINT, IW'($urandom), NW'(k), pick_coord(near, k), fin);
                end
                counted += nd;
            end else if (sel < 84) begin
                // centroid rewrite, often a copy of another slot to force ties
                d = $urandom_range(NUM_DIMS - 1);
                send_item(MODE_LOAD, IW'($urandom),
                          NW'(d),
                          $urandom_range(2) == 0 ?
                              centroid_coord[$urandom_range(NUM_SLOTS - 1)][d] :
                              CW'($urandom),
                          1'($urandom_range(1)));
                counted++;
            end else if (sel < 94) begin
                // lone coordinate in range: breaks up or restarts a point
                d = $urandom_range(nd - 1);
                send_item(MODE_POINT, IW'($urandom), NW'(d),
                          pick_coord($urandom_range(nc - 1), d), 1'($urandom_range(1)));
                counted++;
            end else begin
                // any dim; those past the active count are dropped by the block
                d = $urandom_range(NUM_DIMS - 1);
                send_item(MODE_POINT, IW'($urandom), NW'(d), CW'($urandom),
                          1'($urandom_range(1)));
                if (d < nd) begin
                    counted++;
                end
            end
        end
    endtask

    // Sweep settings, extremes and out-of-range values included, across idling patterns
    task automatic test_setting_sweep();
        run_phase(KW'(16), KW'(16), 0, 0);
        run_phase(KW'(1), KW'(1), 0, 0);
        run_phase(KW'(31), KW'(0), 85, 0);
        run_phase(KW'(0), KW'(31), 85, 0);
        run_phase(KW'(17), KW'(4), 0, 85);
        run_phase(KW'($urandom_range(1, 16)), KW'($urandom_range(1, 16)), 0, 85);
        run_phase(KW'($urandom_range(1, 16)), KW'($urandom_range(1, 16)), 12, 12);
        run_phase(KW'($urandom_range(1, 16)), KW'($urandom_range(1, 16)), 12, 12);
    endtask

    // Receiver: stall at random per cycle
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted assignment against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_assign.size() == 0) begin
                report_mismatch($sformatf("unexpected assignment idx %0d dist %0d",
                                          o_nearest_index, o_nearest_distance));
            end else begin
                head = expected_assign.pop_front();
                if (o_nearest_index !== head.idx) begin
                    report_mismatch($sformatf("nearest_index %0d, want %0d",
                                              o_nearest_index, head.idx));
                end
                if (o_nearest_distance !== head.dist_sq) begin
                    report_mismatch($sformatf("nearest_distance %0d, want %0d",
                                              o_nearest_distance, head.dist_sq));
                end
                if (o_final_assignment !== head.fin) begin
                    report_mismatch($sformatf("final_assignment %0b, want %0b",
                                              o_final_assignment, head.fin));
                end
            end
        end
    end

    // Watchdog: end the run if no item moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_LOAD;
        i_centroid_slot = '0;
        i_dim_index     = '0;
        i_coord_value   = '0;
        i_final_point   = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatches      = 0;
        loads_sent      = 0;
        coords_sent     = 0;
        results_seen    = 0;
        settings_used   = 0;
        cfg_centroids   = ncad_pkg::CNT_RESET;
        cfg_dims        = ncad_pkg::CNT_RESET;
        for (int c = 0; c < NUM_SLOTS; c++) dist_acc[c] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_points();
        test_dim_order();
        test_table_fill();
        test_setting_sweep();
        wait_idle();

        $display("Run covered %0d centroid loads and %0d point coordinates over %0d settings,",
                 loads_sent, coords_sent, settings_used);
        $display("with %0d assignments checked and %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_assign.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
